/* rtl/mbrd_pkg.sv */
// shared types, codes and the crc byte update for the modbus response decoder
package mbrd_pkg;

    typedef enum logic [1:0] {
        KIND_REG    = 2'd0,
        KIND_COIL   = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CRC      = 3'd1,
        ST_TID      = 3'd2,
        ST_EXC      = 3'd3,
        ST_FUNC     = 3'd4,
        ST_BAD_TYPE = 3'd5
    } status_t;

    localparam logic [2:0] REG_LINK_MODE  = 3'd0;
    localparam logic [2:0] REG_START_ADDR = 3'd1;
    localparam logic [2:0] REG_QUANTITY   = 3'd2;
    localparam logic [2:0] REG_WIDTH_32   = 3'd3;
    localparam logic [2:0] REG_VALUE_TYPE = 3'd4;
    localparam logic [2:0] REG_WORD_ORDER = 3'd5;
    localparam logic [2:0] REG_BYTE_ORDER = 3'd6;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [11:0] POS_MAX  = 12'd4095;
    localparam logic [2:0]  TYPE_MAX = 3'd4;

    typedef struct packed {
        logic        link_mode;
        logic [15:0] start_address;
        logic [10:0] quantity;
        logic        reg_width_32;
        logic [2:0]  value_type;
        logic        word_order;
        logic        byte_order;
    } cfg_t;

    // everything one received byte produces
    typedef struct packed {
        logic [7:0]  coil_bits;
        logic [3:0]  coil_cnt;
        logic [15:0] coil_addr;
        logic        reg_vld;
        logic [15:0] reg_addr;
        logic [31:0] reg_val;
        logic [2:0]  reg_type;
        logic        st_vld;
        status_t     st;
        logic [7:0]  exc;
    } byte_res_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/mbrd_parse.sv */
// frame state and per-byte decode of the modbus response stream
module mbrd_parse import mbrd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_acc,
    input  logic [7:0] rx_byte,
    input  logic      frame_end,
    input  cfg_t      cfg,
    output byte_res_t res
);

    logic [11:0] pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] dly_reg, dly_next;
    logic [15:0] tid_reg, tid_next;
    logic [7:0]  fc_reg, fc_next;
    logic [7:0]  bc_reg, bc_next;
    logic [10:0] ic_reg, ic_next;
    logic [31:0] va_reg, va_next;
    logic [2:0]  ferr_reg, ferr_next;

    logic [11:0] hdr, d;
    logic        bad, wide;
    logic [10:0] limit, rem;
    logic        k0, k1;
    logic [4:0]  shift;
    logic [15:0] rx_crc;

    always_comb begin
        hdr       = cfg.link_mode ? 12'd7 : 12'd1;
        bad       = (cfg.value_type > TYPE_MAX) || (cfg.reg_width_32 && cfg.value_type < 3'd2);
        wide      = cfg.reg_width_32 || (cfg.value_type >= 3'd2);
        limit     = (!cfg.reg_width_32 && wide) ? (cfg.quantity >> 1) : cfg.quantity;
        d         = pos_reg - hdr - 12'd2;
        k0        = d[0];
        k1        = wide ? d[1] : 1'b0;
        shift     = {(wide && ((k1 ^ cfg.word_order) == 1'b0)),
                     ((k0 ^ cfg.byte_order) == 1'b0), 3'b000};
        rem       = cfg.quantity - ic_reg;

        crc_next  = (pos_reg >= 12'd2) ? crc_feed(crc_reg, dly_reg[15:8]) : crc_reg;
        dly_next  = {dly_reg[7:0], rx_byte};
        tid_next  = tid_reg;
        ferr_next = ferr_reg;
        fc_next   = fc_reg;
        bc_next   = bc_reg;
        ic_next   = ic_reg;
        va_next   = va_reg;
        res       = '0;
        res.st    = ST_OK;

        if (cfg.link_mode && pos_reg == 12'd1) begin
            if (dly_next == tid_reg) tid_next = tid_reg + 16'd1;
            else ferr_next = ST_TID;
        end

        if (pos_reg == hdr) begin
            fc_next = rx_byte;
        end else if (pos_reg == hdr + 12'd1) begin
            bc_next = rx_byte;
        end else if (pos_reg >= hdr + 12'd2 && ferr_next == 3'd0 && !fc_reg[7]
                     && d < {4'd0, bc_reg}) begin
            if (fc_reg == 8'd1 || fc_reg == 8'd2) begin
                if (ic_reg < cfg.quantity) begin
                    res.coil_cnt = (rem > 11'd8) ? 4'd8 : rem[3:0];
                    res.coil_bits = rx_byte;
                    res.coil_addr = cfg.start_address + {5'd0, ic_reg};
                    ic_next = ic_reg + {7'd0, res.coil_cnt};
                end
            end else if ((fc_reg == 8'd3 || fc_reg == 8'd4) && !bad) begin
                if (ic_reg < limit) begin
                    va_next = va_reg | ({24'd0, rx_byte} << shift);
                    if (k0 && (k1 == wide)) begin
                        res.reg_vld  = 1'b1;
                        res.reg_val  = va_next;
                        res.reg_type = cfg.value_type;
                        res.reg_addr = cfg.start_address +
                                       ((!cfg.reg_width_32 && wide) ? {4'd0, ic_reg, 1'b0}
                                                                    : {5'd0, ic_reg});
                        ic_next = ic_reg + 11'd1;
                        va_next = '0;
                    end
                end
            end
        end

        pos_next = (pos_reg < POS_MAX) ? pos_reg + 12'd1 : pos_reg;
        rx_crc   = {dly_next[7:0], dly_next[15:8]};

        if (frame_end) begin
            res.st_vld = 1'b1;
            if (!cfg.link_mode && (pos_next < 12'd2 || crc_next != rx_crc)) res.st = ST_CRC;
            else if (cfg.link_mode && (pos_next < 12'd2 || ferr_next == ST_TID)) res.st = ST_TID;
            else if (fc_next[7]) begin
                res.st  = ST_EXC;
                res.exc = bc_next;
            end else if (fc_next < 8'd1 || fc_next > 8'd4) res.st = ST_FUNC;
            else if (fc_next >= 8'd3 && bad) res.st = ST_BAD_TYPE;
            pos_next  = '0;
            crc_next  = CRC_INIT;
            dly_next  = '0;
            fc_next   = '0;
            bc_next   = '0;
            ic_next   = '0;
            va_next   = '0;
            ferr_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            crc_reg  <= CRC_INIT;
            dly_reg  <= '0;
            tid_reg  <= '0;
            fc_reg   <= '0;
            bc_reg   <= '0;
            ic_reg   <= '0;
            va_reg   <= '0;
            ferr_reg <= '0;
        end else if (in_acc) begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            dly_reg  <= dly_next;
            tid_reg  <= tid_next;
            fc_reg   <= fc_next;
            bc_reg   <= bc_next;
            ic_reg   <= ic_next;
            va_reg   <= va_next;
            ferr_reg <= ferr_next;
        end
    end

endmodule

/* rtl/modbus_response_decoder_top.sv */
// modbus response decoder top level: config port, result queue and output register
// a result is registered in pend_reg when its byte is accepted, then in the m_ output register
// throughput: one byte per cycle if each byte yields at most one result and m_ does not stall
// coil data bytes yield up to eight results, the closing byte one more, one per cycle unless
// m_ stalls; one byte's emit queue sets the rate; s_tready rises as its last result leaves
// reset: synchronous active-low aresetn clears frame state and transaction id, resets config
module modbus_response_decoder_top import mbrd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic        s_tlast,   // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // item_address, item_value, item_type, frame_status,
                                   // exception_code, zero fill
    output logic [1:0]  m_tuser,   // result_kind
    output logic        m_tlast,   // last_result
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t      cfg_reg;
    byte_res_t res, pend_reg;
    logic [3:0] idx_reg;
    logic [3:0] remain;
    logic       s_acc, out_load, emit;
    logic       out_vld_reg;
    logic [63:0] out_data_reg;
    logic [1:0]  out_kind_reg;
    logic        out_last_reg;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg          <= '0;
            cfg_reg.quantity <= 11'd1;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            case (reg_idx)
                REG_LINK_MODE:  cfg_reg.link_mode     <= pwdata[0];
                REG_START_ADDR: cfg_reg.start_address <= pwdata[15:0];
                REG_QUANTITY:   cfg_reg.quantity      <= pwdata[10:0];
                REG_WIDTH_32:   cfg_reg.reg_width_32  <= pwdata[0];
                REG_VALUE_TYPE: cfg_reg.value_type    <= pwdata[2:0];
                REG_WORD_ORDER: cfg_reg.word_order    <= pwdata[0];
                REG_BYTE_ORDER: cfg_reg.byte_order    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LINK_MODE:  prdata = {31'd0, cfg_reg.link_mode};
            REG_START_ADDR: prdata = {16'd0, cfg_reg.start_address};
            REG_QUANTITY:   prdata = {21'd0, cfg_reg.quantity};
            REG_WIDTH_32:   prdata = {31'd0, cfg_reg.reg_width_32};
            REG_VALUE_TYPE: prdata = {29'd0, cfg_reg.value_type};
            REG_WORD_ORDER: prdata = {31'd0, cfg_reg.word_order};
            REG_BYTE_ORDER: prdata = {31'd0, cfg_reg.byte_order};
            default:        prdata = '0;
        endcase
    end

    mbrd_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_acc    (s_acc),
        .rx_byte   (s_tdata),
        .frame_end (s_tlast),
        .cfg       (cfg_reg),
        .res       (res)
    );

    assign remain   = (pend_reg.coil_cnt - idx_reg) + {3'd0, pend_reg.reg_vld}
                      + {3'd0, pend_reg.st_vld};
    assign out_load = !out_vld_reg || m_tready;
    assign emit     = out_load && remain != 4'd0;
    assign s_tready = (remain == 4'd0) || (remain == 4'd1 && out_load);
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg.coil_cnt <= '0;
            pend_reg.reg_vld  <= 1'b0;
            pend_reg.st_vld   <= 1'b0;
            idx_reg           <= '0;
        end else if (s_acc) begin
            pend_reg <= res;
            idx_reg  <= '0;
        end else if (emit) begin
            if (idx_reg < pend_reg.coil_cnt) idx_reg <= idx_reg + 4'd1;
            else if (pend_reg.reg_vld) pend_reg.reg_vld <= 1'b0;
            else pend_reg.st_vld <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_load) begin
            out_vld_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_data_reg <= '0;
            out_last_reg <= 1'b0;
            if (idx_reg < pend_reg.coil_cnt) begin
                out_kind_reg        <= KIND_COIL;
                out_data_reg[15:0]  <= pend_reg.coil_addr + {12'd0, idx_reg};
                out_data_reg[16]    <= pend_reg.coil_bits[idx_reg[2:0]];
            end else if (pend_reg.reg_vld) begin
                out_kind_reg        <= KIND_REG;
                out_data_reg[15:0]  <= pend_reg.reg_addr;
                out_data_reg[47:16] <= pend_reg.reg_val;
                out_data_reg[50:48] <= pend_reg.reg_type;
            end else begin
                out_kind_reg        <= KIND_STATUS;
                out_data_reg[53:51] <= pend_reg.st;
                out_data_reg[61:54] <= pend_reg.exc;
                out_last_reg        <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= pend_reg.coil_cnt) else $error("coil index past count");
    a_accept_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |-> (remain == 4'd0 || (remain == 4'd1 && out_load)))
        else $error("byte accepted over pending results");
    a_end_gives_status: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tlast |=> pend_reg.st_vld) else $error("frame end without status");
    a_coil_max: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg.coil_cnt <= 4'd8) else $error("more than eight coils per byte");
`endif

endmodule
